// File: rtl/rc_sumd_frame_parser_core_defines.svh
// Assertion macros used by the frame parser controller.
// No dependencies; include by bare file name.
`ifndef RC_SUMD_FRAME_PARSER_CORE_DEFINES_SVH
`define RC_SUMD_FRAME_PARSER_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define RCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check a property on every clock edge, reset included.
`define RCS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: rtl/rcsumd_pkg.sv
// Shared constants, types and functions for the frame parser.
// No dependencies.
package rcsumd_pkg;

  localparam int MAX_CHANNELS = 16;
  localparam int CH_CNT_W     = $clog2(MAX_CHANNELS + 1);
  localparam int POS_W        = $clog2(2 * MAX_CHANNELS + 1);
  localparam int MEM_AW       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int IDX_W        = 4;
  localparam int VAL_W        = 11;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] RAW_MIN  = 16'h1000;
  localparam logic [15:0] RAW_MAX  = 16'h3000;
  localparam logic [10:0] US_BASE  = 11'd988;

  // Configuration register indexes
  localparam logic CFG_SYNC_MAIN = 1'b0;
  localparam logic CFG_SYNC_ALT  = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic sync_ld;
    logic status_ld;
    logic count_ld;
    logic chan_ld;
    logic crch_ld;
    logic emit_clr;
    logic out_ld;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sync_hit;
    logic count_zero;
    logic chan_last;
    logic crc_ok;
    logic emit_last;
    logic out_free;
  } sts_t;

  // CRC-16-CCITT, MSB first, one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Clamp raw channel and map to microseconds
  function automatic logic [VAL_W-1:0] scale_channel(input logic [15:0] raw);
    logic [15:0] r;
    logic [15:0] d;
    r = raw;
    if (r < RAW_MIN) begin
      r = RAW_MIN;
    end
    if (r > RAW_MAX) begin
      r = RAW_MAX;
    end
    d = r - RAW_MIN;
    return US_BASE + VAL_W'(d >> 3);
  endfunction

endpackage

// File: rtl/rcsumd_dp.sv
// Datapath of the frame parser: CRC, frame registers, channel memory and
// result register. Depends on rcsumd_pkg.
module rcsumd_dp
  import rcsumd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic [7:0]        rx_byte_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [IDX_W-1:0]  channel_index_o,
  output logic [VAL_W-1:0]  channel_value_o,
  output logic              has_channel_o,
  output logic [7:0]        frame_status_o,
  output logic              last_of_frame_o
);

  logic [7:0]          sync_main_q, sync_alt_q;
  logic [15:0]         crc_q, crc_d;
  logic [POS_W-1:0]    pos_q;
  logic [CH_CNT_W-1:0] nch_q;
  logic [CH_CNT_W-1:0] nch_rx;
  logic [7:0]          status_q;
  logic [7:0]          crch_q;
  logic [7:0]          pend_q;
  logic [MEM_AW-1:0]   k_q;
  logic [15:0]         mem_q [MAX_CHANNELS];
  logic [15:0]         rd_q;
  logic                out_valid_q;
  logic [IDX_W-1:0]    idx_q;
  logic [VAL_W-1:0]    val_q;
  logic                has_q;
  logic [7:0]          fst_q;
  logic                last_q;
  logic [POS_W:0]      pos_inc;
  logic [POS_W:0]      pos_end;

  assign crc_d   = crc_feed(crc_q, rx_byte_i);
  assign nch_rx  = (rx_byte_i > 8'(MAX_CHANNELS)) ? CH_CNT_W'(MAX_CHANNELS)
                                                  : CH_CNT_W'(rx_byte_i);
  assign pos_inc = (POS_W+1)'(pos_q) + (POS_W+1)'(1);
  assign pos_end = {(POS_W+1-CH_CNT_W)'(0), nch_q} << 1;

  always_comb begin
    sts_o.sync_hit   = (rx_byte_i == sync_main_q) || (rx_byte_i == sync_alt_q);
    sts_o.count_zero = (nch_rx == '0);
    sts_o.chan_last  = (pos_inc >= pos_end);
    sts_o.crc_ok     = ({crch_q, rx_byte_i} == crc_q);
    sts_o.emit_last  = (nch_q == '0) ||
                       ((CH_CNT_W'(k_q) + CH_CNT_W'(1)) == nch_q);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_main_q <= 8'hA8;
      sync_alt_q  <= 8'hA8;
      crc_q       <= '0;
      pos_q       <= '0;
      nch_q       <= '0;
      status_q    <= '0;
      crch_q      <= '0;
      pend_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SYNC_MAIN: sync_main_q <= cfg_wdata_i;
          CFG_SYNC_ALT:  sync_alt_q  <= cfg_wdata_i;
          default:       sync_main_q <= sync_main_q;
        endcase
      end
      if (cmd_i.sync_ld) begin
        crc_q <= crc_feed(16'h0000, rx_byte_i);
        pos_q <= '0;
      end
      if (cmd_i.status_ld) begin
        status_q <= rx_byte_i;
        crc_q    <= crc_d;
      end
      if (cmd_i.count_ld) begin
        crc_q <= crc_d;
        nch_q <= nch_rx;
        pos_q <= '0;
      end
      if (cmd_i.chan_ld) begin
        crc_q <= crc_d;
        pos_q <= pos_inc[POS_W-1:0];
        if (!pos_q[0]) begin
          pend_q <= rx_byte_i;
        end
      end
      if (cmd_i.crch_ld) begin
        crch_q <= rx_byte_i;
      end
      if (cmd_i.emit_clr) begin
        k_q   <= '0;
        pos_q <= '0;
      end else if (cmd_i.out_ld) begin
        k_q <= k_q + MEM_AW'(1);
      end
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Channel store: write the pair on its low byte, read at the emit index
  always_ff @(posedge clk_i) begin
    if (cmd_i.chan_ld && pos_q[0]) begin
      mem_q[pos_q[MEM_AW:1]] <= {pend_q, rx_byte_i};
    end
    rd_q <= mem_q[k_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      fst_q  <= status_q;
      last_q <= sts_o.emit_last;
      if (nch_q == '0) begin
        idx_q <= '0;
        val_q <= '0;
        has_q <= 1'b0;
      end else begin
        idx_q <= IDX_W'(k_q);
        val_q <= scale_channel(rd_q);
        has_q <= 1'b1;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign channel_index_o = idx_q;
  assign channel_value_o = val_q;
  assign has_channel_o   = has_q;
  assign frame_status_o  = fst_q;
  assign last_of_frame_o = last_q;

endmodule

// File: rtl/rcsumd_ctrl.sv
// Controller state machine of the frame parser.
// Depends on rcsumd_pkg and rc_sumd_frame_parser_core_defines.svh.
`include "rc_sumd_frame_parser_core_defines.svh"

module rcsumd_ctrl
  import rcsumd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] ST_HUNT    = 3'd0;
  localparam logic [2:0] ST_STATUS  = 3'd1;
  localparam logic [2:0] ST_COUNT   = 3'd2;
  localparam logic [2:0] ST_CHAN    = 3'd3;
  localparam logic [2:0] ST_CRCH    = 3'd4;
  localparam logic [2:0] ST_CRCL    = 3'd5;
  localparam logic [2:0] ST_EMIT_RD = 3'd6;
  localparam logic [2:0] ST_EMIT_LD = 3'd7;

  logic [2:0] state_q, state_d;
  logic       in_acc;

  assign in_ready_o = (state_q != ST_EMIT_RD) && (state_q != ST_EMIT_LD);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_HUNT: begin
        if (in_acc && sts_i.sync_hit) begin
          cmd_o.sync_ld = 1'b1;
          state_d       = ST_STATUS;
        end
      end
      ST_STATUS: begin
        if (in_acc) begin
          cmd_o.status_ld = 1'b1;
          state_d         = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (in_acc) begin
          cmd_o.count_ld = 1'b1;
          state_d        = sts_i.count_zero ? ST_CRCH : ST_CHAN;
        end
      end
      ST_CHAN: begin
        if (in_acc) begin
          cmd_o.chan_ld = 1'b1;
          if (sts_i.chan_last) begin
            state_d = ST_CRCH;
          end
        end
      end
      ST_CRCH: begin
        if (in_acc) begin
          cmd_o.crch_ld = 1'b1;
          state_d       = ST_CRCL;
        end
      end
      ST_CRCL: begin
        if (in_acc) begin
          cmd_o.emit_clr = 1'b1;
          state_d        = sts_i.crc_ok ? ST_EMIT_RD : ST_HUNT;
        end
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = sts_i.emit_last ? ST_HUNT : ST_EMIT_RD;
        end
      end
      default: begin
        state_d = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  `RCS_ASSERT(a_bad_crc_drops, (state_q == ST_CRCL && in_acc && !sts_i.crc_ok) |=> (state_q == ST_HUNT && !cmd_o.out_ld), "bad CRC frame not dropped")
  `RCS_ASSERT(a_read_then_load, (state_q == ST_EMIT_RD) |=> (state_q == ST_EMIT_LD && !in_ready_o), "emit read not followed by load")
  `RCS_ASSERT(a_last_frees_input, (cmd_o.out_ld && sts_i.emit_last) |=> in_ready_o, "input not reopened after last result")
  `RCS_ASSERT(a_crch_to_crcl, (state_q == ST_CRCH && in_acc) |=> (state_q == ST_CRCL), "CRC low byte phase skipped")

endmodule

// File: rtl/rc_sumd_frame_parser_core.sv
// Top level of the SUMD frame parser: controller plus datapath.
// Depends on rcsumd_pkg, rcsumd_ctrl and rcsumd_dp.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/rx_byte_i) takes one received
//   serial byte per transfer. The parser hunts for either sync byte, then
//   reads status, channel count (clamped to MAX_CHANNELS), 2*N channel
//   bytes and a CRC-16-CCITT sent high byte first.
//   Output channel (out_valid_o/out_ready_i) delivers one transfer per
//   channel of a frame whose CRC matches; a frame with zero channels gives
//   a single transfer with has_channel_o low. Bad frames give nothing.
//   Throughput: one byte per cycle while a frame is received. After the
//   final CRC byte of a good frame the input stays closed while results
//   drain; each result takes a memory read, then a result register load,
//   and a zero-channel frame gives its one result the same way.
//   A stalled receiver holds the result register and freezes the emit
//   sequence; the input reopens as soon as the last result is loaded.
//   Reset clears the parser to sync hunt and both sync registers to 0xA8.
//   Configuration writes (cfg_we_i) take effect at the next edge.
module rc_sumd_frame_parser_core
  import rcsumd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [IDX_W-1:0]  channel_index_o,
  output logic [VAL_W-1:0]  channel_value_o,
  output logic              has_channel_o,
  output logic [7:0]        frame_status_o,
  output logic              last_of_frame_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequence the frame phases and the result drain
  rcsumd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold CRC, frame fields, channel store and the result register
  rcsumd_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .rx_byte_i       (rx_byte_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .has_channel_o   (has_channel_o),
    .frame_status_o  (frame_status_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule

// File: tb/rc_sumd_frame_parser_checker.sv
// Frame prediction and result checking for the SUMD frame parser testbench.
// Watches the config port and both handshake channels of rc_sumd_frame_parser_core.
// Depends on rcsumd_pkg for the channel field widths and register indexes.
module rc_sumd_frame_parser_checker
  import rcsumd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [7:0]       cfg_wdata_i,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [IDX_W-1:0] channel_index_i,
  input  logic [VAL_W-1:0] channel_value_i,
  input  logic             has_channel_i,
  input  logic [7:0]       frame_status_i,
  input  logic             last_of_frame_i,
  output int               expected_pending_o,
  output int               results_checked_o,
  output int               mismatch_count_o
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_STATUS,
    PH_COUNT,
    PH_CHAN,
    PH_CRC_HI,
    PH_CRC_LO
  } parse_phase_e;

  typedef struct packed {
    logic [IDX_W-1:0] chan_idx;
    logic [VAL_W-1:0] chan_val;
    logic             has_chan;
    logic [7:0]       status;
    logic             last_flag;
  } chan_result_t;

  logic [7:0]   sync_main;
  logic [7:0]   sync_alt;
  parse_phase_e phase;
  logic [5:0]   byte_pos;
  logic [4:0]   n_chan;
  logic [15:0]  crc_acc;
  logic [7:0]   crc_hi;
  logic [7:0]   status_q;
  logic [7:0]   high_byte;
  logic [15:0]  raw_q [MAX_CHANNELS];
  chan_result_t expected_q [$];
  int           checked_cnt;
  int           mismatch_cnt;

  // CRC-16-CCITT, MSB first, one byte
  function automatic logic [15:0] crc16_ccitt_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    repeat (8) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // Clamp to 0x1000..0x3000, map to 988..2012 us
  function automatic logic [VAL_W-1:0] pulse_width_us(input logic [15:0] raw);
    logic [15:0] r;
    r = (raw < 16'h1000) ? 16'h1000 : ((raw > 16'h3000) ? 16'h3000 : raw);
    return VAL_W'(16'd988 + ((r - 16'h1000) >> 3));
  endfunction

  task automatic accept_byte(input logic [7:0] b);
    chan_result_t r;
    int           k;
    case (phase)
      PH_STATUS: begin
        status_q = b;
        crc_acc  = crc16_ccitt_byte(crc_acc, b);
        phase    = PH_COUNT;
      end
      PH_COUNT: begin
        crc_acc  = crc16_ccitt_byte(crc_acc, b);
        n_chan   = (b > MAX_CHANNELS) ? 5'(MAX_CHANNELS) : b[4:0];
        byte_pos = '0;
        phase    = (n_chan == 0) ? PH_CRC_HI : PH_CHAN;
      end
      PH_CHAN: begin
        crc_acc = crc16_ccitt_byte(crc_acc, b);
        if (!byte_pos[0]) begin
          high_byte = b;
        end else begin
          raw_q[byte_pos[MEM_AW:1]] = {high_byte, b};
        end
        byte_pos = byte_pos + 6'd1;
        if (int'(byte_pos) >= 2 * int'(n_chan)) begin
          phase = PH_CRC_HI;
        end
      end
      PH_CRC_HI: begin
        crc_hi = b;
        phase  = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        if ({crc_hi, b} == crc_acc) begin
          if (n_chan == 0) begin
            r = '{chan_idx: '0, chan_val: '0, has_chan: 1'b0, status: status_q,
                  last_flag: 1'b1};
            expected_q.push_back(r);
          end else begin
            for (k = 0; k < int'(n_chan); k++) begin
              r.chan_idx  = IDX_W'(k);
              r.chan_val  = pulse_width_us(raw_q[k]);
              r.has_chan  = 1'b1;
              r.status    = status_q;
              r.last_flag = (k + 1 == int'(n_chan));
              expected_q.push_back(r);
            end
          end
        end
        phase    = PH_HUNT;
        byte_pos = '0;
      end
      default: begin
        phase = PH_HUNT;
        if (b == sync_main || b == sync_alt) begin
          crc_acc  = crc16_ccitt_byte(16'h0000, b);
          byte_pos = '0;
          phase    = PH_STATUS;
        end
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  task automatic check_result();
    chan_result_t want;
    if (expected_q.size() == 0) begin
      $error("channel result with none expected: index %0d value %0d",
             channel_index_i, channel_value_i);
      mismatch_cnt++;
    end else begin
      want = expected_q.pop_front();
      compare_field("channel_index", 16'(want.chan_idx), 16'(channel_index_i));
      compare_field("channel_value", 16'(want.chan_val), 16'(channel_value_i));
      compare_field("has_channel", 16'(want.has_chan), 16'(has_channel_i));
      compare_field("frame_status", 16'(want.status), 16'(frame_status_i));
      compare_field("last_of_frame", 16'(want.last_flag), 16'(last_of_frame_i));
      checked_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_main    = 8'hA8;
      sync_alt     = 8'hA8;
      phase        = PH_HUNT;
      byte_pos     = '0;
      n_chan       = '0;
      crc_acc      = '0;
      crc_hi       = '0;
      status_q     = '0;
      high_byte    = '0;
      checked_cnt  = 0;
      mismatch_cnt = 0;
      foreach (raw_q[i]) raw_q[i] = '0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SYNC_MAIN) begin
          sync_main = cfg_wdata_i;
        end else begin
          sync_alt = cfg_wdata_i;
        end
      end
      if (out_valid_i && out_ready_i) begin
        check_result();
      end
      if (in_valid_i && in_ready_i) begin
        accept_byte(rx_byte_i);
      end
    end
    expected_pending_o <= expected_q.size();
    results_checked_o  <= checked_cnt;
    mismatch_count_o   <= mismatch_cnt;
  end

endmodule

// File: tb/testbench.sv
// Top of the SUMD frame parser testbench: clock, reset, byte and frame stimulus, verdict.
// Depends on rcsumd_pkg, rc_sumd_frame_parser_core and rc_sumd_frame_parser_checker.
module testbench;
  import rcsumd_pkg::*;

  // Generous bound, far above the slowest expected run
  localparam int CYCLE_LIMIT  = 200000;
  // Settling margin after the last expected result, before the next write
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_BYTES  = 12;
  localparam int NUM_PHASES   = 6;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idling_e;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic             cfg_idx_i   = CFG_SYNC_MAIN;
  logic [7:0]       cfg_wdata_i = 8'h00;
  logic             in_valid_i  = 1'b0;
  logic [7:0]       rx_byte_i   = 8'h00;
  logic             out_ready_i = 1'b0;
  logic             in_ready_o;
  logic             out_valid_o;
  logic [IDX_W-1:0] channel_index_o;
  logic [VAL_W-1:0] channel_value_o;
  logic             has_channel_o;
  logic [7:0]       frame_status_o;
  logic             last_of_frame_o;

  int          expected_pending;
  int          results_checked;
  int          mismatch_count;
  int          cycle_cnt      = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          bytes_sent     = 0;
  int          frames_sent    = 0;
  logic [7:0]  sync_main_q    = 8'hA8;
  logic [7:0]  sync_alt_q     = 8'hA8;
  logic [15:0] chan_buf [MAX_CHANNELS];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  rc_sumd_frame_parser_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .has_channel_o   (has_channel_o),
    .frame_status_o  (frame_status_o),
    .last_of_frame_o (last_of_frame_o)
  );

  rc_sumd_frame_parser_checker u_frame_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .rx_byte_i          (rx_byte_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .channel_index_i    (channel_index_o),
    .channel_value_i    (channel_value_o),
    .has_channel_i      (has_channel_o),
    .frame_status_i     (frame_status_o),
    .last_of_frame_i    (last_of_frame_o),
    .expected_pending_o (expected_pending),
    .results_checked_o  (results_checked),
    .mismatch_count_o   (mismatch_count)
  );

  // Abort a hung run; a correct one finishes far below the limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_cnt, expected_pending);
      $display("** rc_sumd_frame_parser_core: FAILED **");
      $finish;
    end
  end

  // Result side: stall at random with the current stall rate, one decision per cycle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Frame CRC as the transmitter computes it, to build good and bad frames
  function automatic logic [15:0] frame_crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    repeat (8) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  task automatic set_idling(input idling_e mode);
    case (mode)
      IDLE_SEND: begin send_idle_pct = 63; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 63; end
      IDLE_BOTH: begin send_idle_pct = 16; recv_stall_pct = 16; end
      default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  // Transfer one byte. Drop valid only for an idle gap, so valid is never
  // lowered and raised within the same step; hold it until the transfer.
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  // Build and send a frame from chan_buf; a nonzero crc_flip corrupts the CRC.
  // The CRC covers the count byte as sent, even when it exceeds the channel limit.
  task automatic send_frame(input logic [7:0] sync, input logic [7:0] status,
                            input logic [7:0] count, input logic [15:0] crc_flip);
    logic [7:0]  frame_q [$];
    logic [15:0] crc;
    int          n;
    n = (count > MAX_CHANNELS) ? MAX_CHANNELS : int'(count);
    frame_q = {sync, status, count};
    for (int i = 0; i < n; i++) begin
      frame_q.push_back(chan_buf[i][15:8]);
      frame_q.push_back(chan_buf[i][7:0]);
    end
    crc = 16'h0000;
    foreach (frame_q[i]) crc = frame_crc_step(crc, frame_q[i]);
    crc = crc ^ crc_flip;
    frame_q.push_back(crc[15:8]);
    frame_q.push_back(crc[7:0]);
    foreach (frame_q[i]) send_byte(frame_q[i]);
    frames_sent++;
  endtask

  // Mix in-range values, clamp edges and full-range noise
  task automatic fill_channels();
    logic [15:0] edges [6];
    edges = '{16'h0000, 16'hFFFF, 16'h1000, 16'h3000, 16'h0FFF, 16'h3001};
    foreach (chan_buf[i]) begin
      case ($urandom_range(3))
        0:       chan_buf[i] = 16'($urandom_range(16'h3000, 16'h1000));
        1:       chan_buf[i] = edges[$urandom_range(5)];
        default: chan_buf[i] = 16'($urandom);
      endcase
    end
  endtask

  // Mostly well-formed frames with random content; the rest bad CRCs,
  // line noise and frames cut short
  task automatic random_item();
    int         r;
    logic [7:0] sync;
    logic [7:0] status;
    logic [7:0] count;
    int         k;
    r      = $urandom_range(99);
    sync   = $urandom_range(1) ? sync_main_q : sync_alt_q;
    status = $urandom_range(1) ? 8'h01 : 8'($urandom);
    k      = $urandom_range(99);
    if (k < 10) begin
      count = 8'($urandom_range(255, MAX_CHANNELS + 1));
    end else if (k < 20) begin
      count = 8'(MAX_CHANNELS);
    end else if (k < 32) begin
      count = 8'h00;
    end else begin
      count = 8'($urandom_range(5, 1));
    end
    fill_channels();
    if (r < 70) begin
      send_frame(sync, status, count, 16'h0000);
    end else if (r < 80) begin
      send_frame(sync, status, count, 16'($urandom_range(16'hFFFF, 1)));
    end else if (r < 90) begin
      repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
    end else begin
      count = 8'($urandom_range(5, 1));
      send_byte(sync);
      send_byte(status);
      send_byte(count);
      repeat ($urandom_range(2 * int'(count), 0)) send_byte(8'($urandom));
    end
  endtask

  // Close the input, wait for every expected result, then let a bad frame
  // or late emission settle before the next configuration write
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write both sync registers on consecutive edges; lower the enable once
  task automatic write_sync(input logic [7:0] main_val, input logic [7:0] alt_val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SYNC_MAIN;
    cfg_wdata_i <= main_val;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SYNC_ALT;
    cfg_wdata_i <= alt_val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sync_main_q = main_val;
    sync_alt_q  = alt_val;
  endtask

  initial begin
    int p;
    int phase_start;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames at the reset sync values, no idling.
    // Zero channels with status 0x00: one result, has_channel low.
    set_idling(IDLE_NONE);
    send_frame(8'hA8, 8'h00, 8'h00, 16'h0000);
    // Clamp both edges and exact bounds; status equal to the sync value is plain data
    chan_buf[0] = 16'h0000;
    chan_buf[1] = 16'hFFFF;
    chan_buf[2] = 16'h1000;
    chan_buf[3] = 16'h3000;
    send_frame(8'hA8, 8'hA8, 8'd4, 16'h0000);
    // Sync value as channel data, and a bad CRC: drop the frame
    chan_buf[0] = 16'hA8A8;
    send_frame(8'hA8, 8'h01, 8'd1, 16'h0001);
    drain();

    // Random phases: each its own sync setting, idling modes in turn
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       write_sync(8'hA8, 8'hA8);
        1:       write_sync(8'h00, 8'hFF);
        2:       write_sync(8'hFF, 8'h00);
        4:       write_sync(8'($urandom), 8'hA8);
        default: write_sync(8'($urandom), 8'($urandom));
      endcase
      set_idling(idling_e'(p % 4));
      phase_start = bytes_sent;
      if (p == 0) begin
        // Count far above the limit: clamp to the maximum channel count
        fill_channels();
        send_frame(sync_main_q, 8'h01, 8'hFF, 16'h0000);
      end
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        random_item();
      end
      drain();
    end

    $display("Sent %0d bytes in %0d frames under %0d sync settings and four idling modes,",
             bytes_sent, frames_sent, NUM_PHASES + 1);
    $display("checked %0d channel results with %0d mismatches.",
             results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("** rc_sumd_frame_parser_core: PASSED **");
    end else begin
      $display("** rc_sumd_frame_parser_core: FAILED **");
    end
    $finish;
  end

endmodule
